// ===== rtl/core/sha1md_pkg.sv =====
// SHA-1 message digest: shared types and constants.
// Used by sha1md_core and sha1_message_digest_top; depends on nothing.
`default_nettype none

package sha1md_pkg;

    typedef logic [31:0] t_word;

    localparam int NumWords = 16;
    localparam int NumChain = 5;

    localparam logic [6:0] Phase1End = 7'd20;
    localparam logic [6:0] Phase2End = 7'd40;
    localparam logic [6:0] Phase3End = 7'd60;
    localparam logic [6:0] RoundDone = 7'd80;
    localparam logic [3:0] LenHiWord = 4'd14;

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam t_word H0 = 32'h67452301;
    localparam t_word H1 = 32'hEFCDAB89;
    localparam t_word H2 = 32'h98BADCFE;
    localparam t_word H3 = 32'h10325476;
    localparam t_word H4 = 32'hC3D2E1F0;

    localparam logic [7:0] PadByte     = 8'h80;
    localparam logic [5:0] FillLast    = 6'd63;
    localparam logic [2:0] LastWordIdx = 3'd4;

    typedef struct packed {
        logic        start;
        logic        init_chain;
        logic        wr_byte;
        logic [7:0]  wr_data;
        logic [5:0]  fill;
        logic        zero_tail;
        logic        zero_low;
        logic        wr_len;
        logic [63:0] len_bits;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

`default_nettype wire

// ===== rtl/core/sha1md_core.sv =====
// SHA-1 compression core: block buffer, message schedule, shared round unit, chaining value.
// Depends on sha1md_pkg.
`default_nettype none

module sha1md_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sha1md_pkg::t_core_ctl i_ctl,
    input  wire logic [2:0]            i_rd_idx,
    output sha1md_pkg::t_word          o_rd_word,
    output sha1md_pkg::t_core_sts      o_sts
);

    sha1md_pkg::t_word r_w [sha1md_pkg::NumWords];
    sha1md_pkg::t_word r_h [sha1md_pkg::NumChain];
    sha1md_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    logic [6:0]        r_round;
    logic              r_run;

    sha1md_pkg::t_word w_mix, n_w15, n_a, w_f, w_k;
    logic              w_step, w_done;
    logic [3:0]        w_idx;

    assign w_done = r_run && (r_round == sha1md_pkg::RoundDone);
    assign w_step = r_run && !w_done;
    assign w_idx  = i_ctl.fill[5:2];
    assign o_sts  = '{busy: r_run, done: w_done};

    always_comb begin
        w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        n_w15 = {w_mix[30:0], w_mix[31]};
        if (r_round < sha1md_pkg::Phase1End) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = sha1md_pkg::K0;
        end else if (r_round < sha1md_pkg::Phase2End) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1md_pkg::K1;
        end else if (r_round < sha1md_pkg::Phase3End) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = sha1md_pkg::K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1md_pkg::K3;
        end
        n_a = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
    end

    always_comb begin
        case (i_rd_idx)
            3'd0:    o_rd_word = r_h[0];
            3'd1:    o_rd_word = r_h[1];
            3'd2:    o_rd_word = r_h[2];
            3'd3:    o_rd_word = r_h[3];
            3'd4:    o_rd_word = r_h[4];
            default: o_rd_word = '0;
        endcase
    end

    // Block buffer doubles as the schedule window: shift one word per round.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            for (int i = 0; i < sha1md_pkg::NumWords - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[sha1md_pkg::NumWords - 1] <= n_w15;
        end else begin
            for (int i = 0; i < sha1md_pkg::NumWords; i++) begin
                if ((i_ctl.zero_tail && (4'(i) > w_idx)) ||
                    (i_ctl.zero_low && (4'(i) < sha1md_pkg::LenHiWord))) begin
                    r_w[i] <= '0;
                end
            end
            if (i_ctl.wr_byte) begin
                case (i_ctl.fill[1:0])
                    2'd0:    r_w[w_idx] <= {i_ctl.wr_data, 24'h0};
                    2'd1:    r_w[w_idx] <= r_w[w_idx] | {8'h0, i_ctl.wr_data, 16'h0};
                    2'd2:    r_w[w_idx] <= r_w[w_idx] | {16'h0, i_ctl.wr_data, 8'h0};
                    default: r_w[w_idx] <= r_w[w_idx] | {24'h0, i_ctl.wr_data};
                endcase
            end
            if (i_ctl.wr_len) begin
                r_w[14] <= i_ctl.len_bits[63:32];
                r_w[15] <= i_ctl.len_bits[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (w_step) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_round <= '0;
            r_h[0]  <= sha1md_pkg::H0;
            r_h[1]  <= sha1md_pkg::H1;
            r_h[2]  <= sha1md_pkg::H2;
            r_h[3]  <= sha1md_pkg::H3;
            r_h[4]  <= sha1md_pkg::H4;
        end else begin
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_round <= '0;
            end else if (w_step) begin
                r_round <= r_round + 7'd1;
            end else if (w_done) begin
                r_run  <= 1'b0;
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_ctl.init_chain) begin
                r_h[0] <= sha1md_pkg::H0;
                r_h[1] <= sha1md_pkg::H1;
                r_h[2] <= sha1md_pkg::H2;
                r_h[3] <= sha1md_pkg::H3;
                r_h[4] <= sha1md_pkg::H4;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_message_digest_top.sv =====
// SHA-1 message digest top level: stream ports, padding sequencer, digest output register.
// Depends on sha1md_pkg and sha1md_core.
//
//  channel   direction  tdata               tuser            tlast
//  s_axis    in         data_byte [7:0]     no_byte [0]      end_of_message
//  m_axis    out        digest_word [31:0]  word_index [2:0] last_word
//
// A byte that does not fill a block and does not end the message leaves tready high.
// A byte that completes a 64-byte block holds tready low while the block is compressed:
// 80 rounds through the single round unit and one chaining add.
// End of message adds a padding step, a length step, one or two compressions
// and five digest transactions; a stalled m_axis holds the sequencer.
// Reset (synchronous, active low) restores the initial chaining value and empties the block.
`default_nettype none

module sha1_message_digest_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,  // [0] no_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,  // [2:0] word_index
    output logic             m_axis_tlast
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COMP = 5'b00010,
        S_PAD  = 5'b00100,
        S_LEN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state, n_state, r_ret, n_ret;
    logic               r_extra, n_extra;
    logic [5:0]         r_fill, n_fill;
    logic [60:0]        r_msg, n_msg;
    logic [2:0]         r_oidx, n_oidx;
    logic               r_ovalid, n_ovalid;
    sha1md_pkg::t_word  r_odata;
    logic [2:0]         r_oword;
    logic               r_olast;

    sha1md_pkg::t_core_ctl w_ctl;
    sha1md_pkg::t_core_sts w_sts;
    sha1md_pkg::t_word     w_rd_word;
    logic                  w_in_acc, w_out_load;

    sha1md_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_idx  (r_oidx),
        .o_rd_word (w_rd_word),
        .o_sts     (w_sts)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oword;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_extra    = r_extra;
        n_fill     = r_fill;
        n_msg      = r_msg;
        n_oidx     = r_oidx;
        w_out_load = 1'b0;
        w_ctl      = '0;
        w_ctl.fill = r_fill;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!s_axis_tuser[0]) begin
                        w_ctl.wr_byte = 1'b1;
                        w_ctl.wr_data = s_axis_tdata;
                        n_fill        = r_fill + 6'd1;
                        n_msg         = r_msg + 61'd1;
                    end
                    if (!s_axis_tuser[0] && (r_fill == sha1md_pkg::FillLast)) begin
                        w_ctl.start = 1'b1;
                        n_ret       = s_axis_tlast ? S_PAD : S_IDLE;
                        n_state     = S_COMP;
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_ctl.wr_byte   = 1'b1;
                w_ctl.wr_data   = sha1md_pkg::PadByte;
                w_ctl.zero_tail = 1'b1;
                n_fill          = r_fill + 6'd1;
                // no room left for the length: compress an extra block first
                if (r_fill[5:3] == 3'b111) begin
                    w_ctl.start = 1'b1;
                    n_ret       = S_LEN;
                    n_extra     = 1'b1;
                    n_state     = S_COMP;
                end else begin
                    n_extra = 1'b0;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                w_ctl.zero_low = r_extra;
                w_ctl.wr_len   = 1'b1;
                w_ctl.len_bits = {r_msg, 3'b000};
                w_ctl.start    = 1'b1;
                n_ret          = S_OUT;
                n_state        = S_COMP;
            end
            S_COMP: begin
                if (w_sts.done) begin
                    n_state = r_ret;
                    n_oidx  = '0;
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    if (r_oidx == sha1md_pkg::LastWordIdx) begin
                        w_ctl.init_chain = 1'b1;
                        n_fill           = '0;
                        n_msg            = '0;
                        n_state          = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_out_load) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_extra  <= 1'b0;
            r_fill   <= '0;
            r_msg    <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_extra  <= n_extra;
            r_fill   <= n_fill;
            r_msg    <= n_msg;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= w_rd_word;
            r_oword <= r_oidx;
            r_olast <= (r_oidx == sha1md_pkg::LastWordIdx);
        end
    end

    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.busy)
        else $error("input ready while the round unit is busy");

    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_COMP))
        else $error("compression finished outside the compress state");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_oidx == sha1md_pkg::LastWordIdx)) |=>
            ((r_state == S_IDLE) && (r_fill == 6'd0) && (r_msg == 61'd0)))
        else $error("message state not cleared after the final digest word");

endmodule

`default_nettype wire
